// ===== design/crgg_pkg.sv =====
// ----------------------------------------------------------------------------
// crgg_pkg
// Shared types and constants for the centered-window green pixel gate.
// ----------------------------------------------------------------------------
package crgg_pkg;

	// Frame defaults for the top-level parameters
	localparam int IMG_COLS_DEF = 640;
	localparam int IMG_ROWS_DEF = 480;

	// Field widths
	localparam int PIX_W      = 8;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 9;
	localparam int HUE_W      = 8;
	localparam int CNT_W      = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Fixed-point HSV conversion
	localparam int HSV_SHIFT = 12;
	localparam int SAT_SCALE = 255;
	localparam int HUE_SCALE = 180;
	localparam int HNUM_W    = 12;
	localparam int SDIV_W    = 20;
	localparam int HDIV_W    = 17;
	localparam int SPROD_W   = 21;
	localparam int HPROD_W   = 24;
	localparam int SVAL_W    = SPROD_W - HSV_SHIFT;
	localparam int HRAW_W    = HPROD_W - HSV_SHIFT;

	// Queue between classifier and counter
	localparam int QDEPTH = 8;
	localparam int QPTR_W = 3;
	localparam int QLVL_W = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIN_COLS        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_ROWS        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_MIN         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_MAX         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_MIN         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_MIN         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 3'd6;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             end_of_frame;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0] match_count;
		logic             allowed;
	} out_t;

	typedef struct packed {
		logic [COL_W-1:0] win_cols;
		logic [ROW_W-1:0] win_rows;
		logic [HUE_W-1:0] hue_min;
		logic [HUE_W-1:0] hue_max;
		logic [PIX_W-1:0] sat_min;
		logic [PIX_W-1:0] val_min;
		logic [CNT_W-1:0] count_threshold;
	} cfg_t;

	// One classified pixel as it travels to the counter
	typedef struct packed {
		logic match;
		logic eof;
	} item_t;

endpackage

// ===== design/crgg_front.sv =====
// ----------------------------------------------------------------------------
// crgg_front
// Three-stage classifier: window test and HSV threshold test per pixel.
// ----------------------------------------------------------------------------
module crgg_front #(
	parameter int IMG_COLS = crgg_pkg::IMG_COLS_DEF,
	parameter int IMG_ROWS = crgg_pkg::IMG_ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  crgg_pkg::in_t               pix,
	input  crgg_pkg::cfg_t              cfg,
	input  logic [crgg_pkg::QLVL_W-1:0] q_level,
	output logic                        push,
	output crgg_pkg::item_t             push_item
);

	localparam int XFB = $clog2(IMG_COLS + 1);
	localparam int XW  = ((XFB > crgg_pkg::COL_W) ? XFB : crgg_pkg::COL_W) + 1;
	localparam int YFB = $clog2(IMG_ROWS + 1);
	localparam int YW  = ((YFB > crgg_pkg::ROW_W) ? YFB : crgg_pkg::ROW_W) + 1;

	// Reciprocal tables, rounded to nearest
	logic [crgg_pkg::SDIV_W-1:0] sdiv_tab [256];
	logic [crgg_pkg::HDIV_W-1:0] hdiv_tab [256];

	for (genvar i = 0; i < 256; i++) begin : g_recip
		localparam int SDen = (i == 0) ? 1 : 2 * i;
		localparam int SVal = (i == 0) ? 0 :
			(2 * (crgg_pkg::SAT_SCALE << crgg_pkg::HSV_SHIFT) + i) / SDen;
		localparam int HDen = (i == 0) ? 1 : 12 * i;
		localparam int HVal = (i == 0) ? 0 :
			(2 * (crgg_pkg::HUE_SCALE << crgg_pkg::HSV_SHIFT) + 6 * i) / HDen;
		assign sdiv_tab[i] = crgg_pkg::SDIV_W'(SVal);
		assign hdiv_tab[i] = crgg_pkg::HDIV_W'(HVal);
	end

	logic                                   fire;
	logic [crgg_pkg::PIX_W-1:0]             vmax, vmin, diff;
	logic signed [crgg_pkg::HNUM_W-1:0]     bs, gs, rs, ds, hnum;

	logic                                   vld_s1, vld_s2, vld_s3;
	logic [crgg_pkg::PIX_W-1:0]             v_s1, v_s2, v_s3;
	logic [crgg_pkg::PIX_W-1:0]             diff_s1, diff_s2;
	logic signed [crgg_pkg::HNUM_W-1:0]     hnum_s1, hnum_s2;
	logic [crgg_pkg::COL_W-1:0]             col_s1;
	logic [crgg_pkg::ROW_W-1:0]             row_s1;
	logic                                   eof_s1, eof_s2, eof_s3;
	logic [crgg_pkg::SDIV_W-1:0]            sdiv_s2;
	logic [crgg_pkg::HDIV_W-1:0]            hdiv_s2;
	logic                                   hit_s2, hit_s3;
	logic [crgg_pkg::SPROD_W-1:0]           sprod_s3;
	logic signed [crgg_pkg::HPROD_W-1:0]    hprod_s3;

	logic [XW-1:0]                          x_size, x_off, x_end, x_pos;
	logic [YW-1:0]                          y_size, y_off, y_end, y_pos;
	logic                                   hit;

	logic [crgg_pkg::SPROD_W-1:0]           s_sum;
	logic [crgg_pkg::SVAL_W-1:0]            s_val;
	logic signed [crgg_pkg::HPROD_W-1:0]    h_sum;
	logic signed [crgg_pkg::HRAW_W-1:0]     h_raw, h_adj;
	logic [crgg_pkg::HUE_W:0]               h_val;
	logic [crgg_pkg::QLVL_W-1:0]            inflight;

	// Keep room in the queue for every word already inside the pipeline.
	assign inflight = crgg_pkg::QLVL_W'(vld_s1) + crgg_pkg::QLVL_W'(vld_s2)
		+ crgg_pkg::QLVL_W'(vld_s3);
	assign pix_ready = (q_level + inflight) < crgg_pkg::QLVL_W'(crgg_pkg::QDEPTH);
	assign fire = pix_valid && pix_ready;

	always_comb begin
		vmax = pix.blue;
		vmin = pix.blue;
		if (pix.green > vmax) vmax = pix.green;
		if (pix.red > vmax) vmax = pix.red;
		if (pix.green < vmin) vmin = pix.green;
		if (pix.red < vmin) vmin = pix.red;
		diff = vmax - vmin;
		bs = signed'(crgg_pkg::HNUM_W'(pix.blue));
		gs = signed'(crgg_pkg::HNUM_W'(pix.green));
		rs = signed'(crgg_pkg::HNUM_W'(pix.red));
		ds = signed'(crgg_pkg::HNUM_W'(diff));
		if (vmax == pix.red) begin
			hnum = gs - bs;
		end else if (vmax == pix.green) begin
			hnum = bs - rs + (ds <<< 1);
		end else begin
			hnum = rs - gs + (ds <<< 2);
		end
	end

	// Window bounds follow the registers directly.
	always_comb begin
		x_size = XW'(cfg.win_cols);
		if (cfg.win_cols == '0) x_size = XW'(1);
		else if (XW'(cfg.win_cols) > XW'(IMG_COLS)) x_size = XW'(IMG_COLS);
		x_off = (XW'(IMG_COLS) - x_size) >> 1;
		x_end = x_off + x_size;
		x_pos = XW'(col_s1);

		y_size = YW'(cfg.win_rows);
		if (cfg.win_rows == '0) y_size = YW'(1);
		else if (YW'(cfg.win_rows) > YW'(IMG_ROWS)) y_size = YW'(IMG_ROWS);
		y_off = (YW'(IMG_ROWS) - y_size) >> 1;
		y_end = y_off + y_size;
		y_pos = YW'(row_s1);

		hit = (x_pos >= x_off) && (x_pos < x_end) && (y_pos >= y_off) && (y_pos < y_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= fire;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		v_s1     <= vmax;
		diff_s1  <= diff;
		hnum_s1  <= hnum;
		col_s1   <= pix.col;
		row_s1   <= pix.row;
		eof_s1   <= pix.end_of_frame;

		v_s2     <= v_s1;
		diff_s2  <= diff_s1;
		hnum_s2  <= hnum_s1;
		sdiv_s2  <= sdiv_tab[v_s1];
		hdiv_s2  <= hdiv_tab[diff_s1];
		hit_s2   <= hit;
		eof_s2   <= eof_s1;

		v_s3     <= v_s2;
		sprod_s3 <= crgg_pkg::SPROD_W'(diff_s2) * crgg_pkg::SPROD_W'(sdiv_s2);
		hprod_s3 <= crgg_pkg::HPROD_W'(hnum_s2)
			* signed'(crgg_pkg::HPROD_W'(hdiv_s2));
		hit_s3   <= hit_s2;
		eof_s3   <= eof_s2;
	end

	// Round to nearest, then wrap a negative hue into range.
	always_comb begin
		s_sum = sprod_s3 + crgg_pkg::SPROD_W'(1 << (crgg_pkg::HSV_SHIFT - 1));
		s_val = s_sum[crgg_pkg::SPROD_W-1:crgg_pkg::HSV_SHIFT];
		h_sum = hprod_s3 + crgg_pkg::HPROD_W'(1 << (crgg_pkg::HSV_SHIFT - 1));
		h_raw = h_sum[crgg_pkg::HPROD_W-1:crgg_pkg::HSV_SHIFT];
		h_adj = h_raw[crgg_pkg::HRAW_W-1] ? h_raw + crgg_pkg::HRAW_W'(crgg_pkg::HUE_SCALE)
			: h_raw;
		h_val = h_adj[crgg_pkg::HUE_W:0];
	end

	assign push = vld_s3;
	assign push_item.eof = eof_s3;
	assign push_item.match = hit_s3
		&& (h_val >= {1'b0, cfg.hue_min})
		&& (h_val <= {1'b0, cfg.hue_max})
		&& (s_val >= crgg_pkg::SVAL_W'(cfg.sat_min))
		&& (v_s3 >= cfg.val_min);

endmodule

// ===== design/crgg_queue.sv =====
// ----------------------------------------------------------------------------
// crgg_queue
// Small first-in first-out queue of classified pixels.
// ----------------------------------------------------------------------------
module crgg_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  crgg_pkg::item_t             push_item,
	input  logic                        pop,
	output logic                        head_valid,
	output crgg_pkg::item_t             head,
	output logic [crgg_pkg::QLVL_W-1:0] level
);

	crgg_pkg::item_t             mem_q [crgg_pkg::QDEPTH];
	logic [crgg_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [crgg_pkg::QLVL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	assign head_valid = (level_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign level      = level_q;

endmodule

// ===== design/crgg_back.sv =====
// ----------------------------------------------------------------------------
// crgg_back
// Match counter with saturation and the result output register.
// ----------------------------------------------------------------------------
module crgg_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  crgg_pkg::item_t            head,
	output logic                       pop,
	input  logic [crgg_pkg::CNT_W-1:0] threshold,
	output logic                       res_valid,
	input  logic                       res_ready,
	output crgg_pkg::out_t             res
);

	logic [crgg_pkg::CNT_W-1:0] count_q, count_next;
	logic                       res_valid_q;
	crgg_pkg::out_t             res_q;

	// A frame end needs the output slot free; other words drain at once.
	assign pop = head_valid && (!head.eof || !res_valid_q || res_ready);

	assign count_next = (head.match && (count_q != crgg_pkg::CNT_MAX))
		? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) count_q <= head.eof ? '0 : count_next;
			if (pop && head.eof) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.eof) begin
			res_q.match_count <= count_next;
			res_q.allowed     <= (count_next >= threshold);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== design/center_roi_green_pixel_gate_top.sv =====
// ----------------------------------------------------------------------------
// center_roi_green_pixel_gate_top
// Counts pixels of a set color inside a centered window, once per frame.
// ----------------------------------------------------------------------------
// Pixels come in on the pix channel (valid/ready), one word per pixel with
// its color, column, row and an end-of-frame mark. A result word leaves on
// the res channel (valid/ready) for each pixel marked end of frame; it holds
// the frame's match count and whether that count reaches the threshold.
// Registers are written over the cfg channel, which is always ready; write
// them only while no pixel is in flight.
// The classifier is a three-stage pipeline and takes one pixel per cycle
// while pix_ready is high. It feeds an eight-entry queue that the counter
// drains at one word per cycle unless a frame end waits on the output slot;
// with a ready receiver the block sustains one pixel per clock. Each frame
// end passes the stages, queue and result register. On a receiver stall,
// the counter keeps consuming pixels until it reaches the next end-of-frame
// word; the queue then fills and pix_ready drops. Reset loads the register
// defaults, clears the counter and empties the queue and pipeline.
// ----------------------------------------------------------------------------
module center_roi_green_pixel_gate_top #(
	parameter int IMG_COLS = crgg_pkg::IMG_COLS_DEF,
	parameter int IMG_ROWS = crgg_pkg::IMG_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_ready,
	input  crgg_pkg::in_t                   pix,
	output logic                            res_valid,
	input  logic                            res_ready,
	output crgg_pkg::out_t                  res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [crgg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crgg_pkg::CFG_DATA_W-1:0] cfg_data
);

	crgg_pkg::cfg_t              cfg_q;
	logic                        push, pop, head_valid;
	crgg_pkg::item_t             push_item, head;
	logic [crgg_pkg::QLVL_W-1:0] q_level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_cols        <= crgg_pkg::COL_W'(50);
			cfg_q.win_rows        <= crgg_pkg::ROW_W'(50);
			cfg_q.hue_min         <= crgg_pkg::HUE_W'(25);
			cfg_q.hue_max         <= crgg_pkg::HUE_W'(100);
			cfg_q.sat_min         <= crgg_pkg::PIX_W'(20);
			cfg_q.val_min         <= crgg_pkg::PIX_W'(40);
			cfg_q.count_threshold <= crgg_pkg::CNT_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				crgg_pkg::REG_WIN_COLS:
					cfg_q.win_cols <= cfg_data[crgg_pkg::COL_W-1:0];
				crgg_pkg::REG_WIN_ROWS:
					cfg_q.win_rows <= cfg_data[crgg_pkg::ROW_W-1:0];
				crgg_pkg::REG_HUE_MIN:
					cfg_q.hue_min <= cfg_data[crgg_pkg::HUE_W-1:0];
				crgg_pkg::REG_HUE_MAX:
					cfg_q.hue_max <= cfg_data[crgg_pkg::HUE_W-1:0];
				crgg_pkg::REG_SAT_MIN:
					cfg_q.sat_min <= cfg_data[crgg_pkg::PIX_W-1:0];
				crgg_pkg::REG_VAL_MIN:
					cfg_q.val_min <= cfg_data[crgg_pkg::PIX_W-1:0];
				crgg_pkg::REG_COUNT_THRESHOLD:
					cfg_q.count_threshold <= cfg_data[crgg_pkg::CNT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	crgg_front #(
		.IMG_COLS (IMG_COLS),
		.IMG_ROWS (IMG_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.cfg       (cfg_q),
		.q_level   (q_level),
		.push      (push),
		.push_item (push_item)
	);

	crgg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.level      (q_level)
	);

	crgg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.threshold  (cfg_q.count_threshold),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// The credit check must keep the queue from ever overfilling.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= crgg_pkg::QLVL_W'(crgg_pkg::QDEPTH))
		else $error("queue level above its depth");

	// A frame end must never overwrite a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.eof) |-> (!res_valid || res_ready))
		else $error("result overwritten while stalled");

	// A taken result with no new frame end behind it leaves the output empty.
	a_res_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && !(pop && head.eof)) |=> !res_valid)
		else $error("result stayed valid after it was taken");

endmodule
